@@ rtl/ntr_pkg.sv @@
// shared types and constants of the nibble track reader
package ntr_pkg;

  // fixed field widths
  localparam int CMD_W     = 2;
  localparam int ADDR_W    = 18;
  localparam int DATA_W    = 8;
  localparam int QT_W      = 8;
  localparam int CYC_W     = 48;
  localparam int LEN_W     = 13;
  localparam int TCNT_W    = 6;
  localparam int TRACK_W   = QT_W - 2;
  localparam int PROD_W    = TRACK_W + LEN_W;
  localparam int CFG_IDX_W = 1;

  // shared divider, eight quotient bits per clock
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = 7;
  localparam int DIV_W     = DIV_BITS * DIV_STEPS;
  localparam int DIV_CNT_W = 3;

  localparam logic [LEN_W-1:0]  TRACK_LENGTH_RST = 13'd6384;
  localparam logic [TCNT_W-1:0] TRACK_COUNT_RST  = 6'd35;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TRACK_LENGTH = 1'b0,
    CFG_TRACK_COUNT  = 1'b1
  } cfg_idx_e;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_SEEK  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEEK,
    ST_STEPS,
    ST_POS,
    ST_ADDR,
    ST_MEM
  } state_e;

endpackage

@@ rtl/nibble_track_reader_top.sv @@
// nibble track reader: spinning disk track emulation over an image memory
//
// The block holds a raw disk image of IMAGE_BYTES bytes in a single-port-write,
// single-port-read synchronous memory and emulates a spinning track under the
// head. A write item stores one image byte (ignored when the address is past
// the image) and leaves the block idle. A seek item selects track quarter_track/4,
// clamped to the last track present, and sets the track base to track times
// track_length reduced modulo the image size by repeated compare-subtract
// passes. A read item carries the CPU cycle count; the whole byte times
// (BYTE_TIME_CYCLES each) elapsed since the point reached by the last advance
// move the read position on modulo track_length, and the byte under the head
// comes back as one result item. A read is accepted, its byte count is found
// on the shared divider and, when the head has moved a whole byte, the new
// position modulo the track length on the same divider; then the memory is
// read and the byte goes to the output register once that is free. The
// divider retires eight quotient bits per clock. A cycle count below the last
// one counts as no time gone by. Only one item is worked on at a time; a new
// item is taken while an earlier result still sits in the output register.
// Image bytes never written read as undefined values. Configuration writes
// (track_length, track_count) are always accepted and are expected only while
// the block is idle; a zero in either is treated as one.
module nibble_track_reader_top #(
  parameter int IMAGE_BYTES      = 262144,
  parameter int BYTE_TIME_CYCLES = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // item input channel
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [ntr_pkg::CMD_W-1:0]    command_i,
  input  logic [ntr_pkg::ADDR_W-1:0]   byte_address_i,
  input  logic [ntr_pkg::DATA_W-1:0]   write_data_i,
  input  logic [ntr_pkg::QT_W-1:0]     quarter_track_i,
  input  logic [ntr_pkg::CYC_W-1:0]    cycle_count_i,
  // result channel
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [ntr_pkg::DATA_W-1:0]   nibble_o,
  // configuration write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ntr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ntr_pkg::LEN_W-1:0]    cfg_data_i
);
  import ntr_pkg::*;

  // image address width and the widths needed to hold the image size itself
  localparam int AW = $clog2(IMAGE_BYTES);
  localparam int XW = (ADDR_W > AW + 1) ? ADDR_W : AW + 1;
  localparam int RW = (PROD_W > AW + 1) ? PROD_W : AW + 1;
  localparam logic [XW-1:0]    IMG_X   = XW'(IMAGE_BYTES);
  localparam logic [RW-1:0]    IMG_R   = RW'(IMAGE_BYTES);
  localparam logic [AW:0]      IMG_S   = (AW + 1)'(IMAGE_BYTES);
  localparam logic [LEN_W-1:0] BTC     = LEN_W'(BYTE_TIME_CYCLES);

  // image memory, contents undefined until written
  logic [DATA_W-1:0] image_mem [IMAGE_BYTES];
  logic [DATA_W-1:0] rd_data_q;
  logic              mem_we;
  logic              mem_re;
  logic [AW-1:0]     wr_idx;
  logic [AW-1:0]     rd_idx;

  // configuration registers
  logic [LEN_W-1:0]  track_length_q;
  logic [TCNT_W-1:0] track_count_q;
  logic [LEN_W-1:0]  eff_len;
  logic [TCNT_W-1:0] eff_cnt;

  // control and head state
  state_e            state_q, state_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] nibble_q, nibble_d;
  logic [LEN_W-1:0]  pos_q, pos_d;
  logic [AW-1:0]     base_q, base_d;
  logic [CYC_W-1:0]  last_q, last_d;
  logic [CYC_W-1:0]  now_q, now_d;
  logic [RW-1:0]     red_q, red_d;

  // shared restoring divider
  logic [DIV_W-1:0]     div_quo_q, div_quo_d;
  logic [LEN_W-1:0]     div_rem_q, div_rem_d;
  logic [LEN_W-1:0]     div_dvs_q, div_dvs_d;
  logic [DIV_CNT_W-1:0] div_cnt_q, div_cnt_d;
  logic [DIV_W-1:0]     step_quo;
  logic [LEN_W-1:0]     step_rem;
  logic [LEN_W:0]       step_part;

  // item decode
  logic              in_accept;
  logic [XW-1:0]     wr_wide;
  logic              wr_in_range;
  logic [TRACK_W-1:0] track_raw;
  logic [TRACK_W-1:0] track_sel;
  logic [PROD_W-1:0]  track_prod;
  logic [CYC_W-1:0]   delta;
  logic [CYC_W-1:0]   steps;
  logic [CYC_W:0]     pos_sum;
  logic [AW:0]        addr_sum;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign nibble_o    = nibble_q;
  assign cfg_ready_o = 1'b1;

  // a zero register value counts as one
  assign eff_len = (track_length_q == '0) ? LEN_W'(1) : track_length_q;
  assign eff_cnt = (track_count_q == '0) ? TCNT_W'(1) : track_count_q;

  // write address check against the image size
  assign wr_wide     = XW'(byte_address_i);
  assign wr_in_range = (wr_wide < IMG_X);
  assign wr_idx      = wr_wide[AW-1:0];

  // seek: quarter track to track, clamped to the last track present
  assign track_raw  = quarter_track_i[QT_W-1:2];
  assign track_sel  = (TCNT_W'(track_raw) >= eff_cnt) ? TRACK_W'(eff_cnt - TCNT_W'(1))
                                                      : track_raw;
  assign track_prod = PROD_W'(track_sel) * PROD_W'(eff_len);

  // read: cycles gone by, a count going backwards counts as none
  assign delta   = (cycle_count_i > last_q) ? (cycle_count_i - last_q) : '0;
  assign steps   = div_quo_q[CYC_W-1:0];
  assign pos_sum = (CYC_W + 1)'(steps) + (CYC_W + 1)'(pos_q);

  // byte under the head, base and position both below the image size
  assign addr_sum = (AW + 1)'(base_q) + (AW + 1)'(pos_q);
  assign rd_idx   = (addr_sum >= IMG_S) ? AW'(addr_sum - IMG_S) : addr_sum[AW-1:0];

  // eight restoring divide steps per clock
  always_comb begin
    step_quo  = div_quo_q;
    step_rem  = div_rem_q;
    step_part = '0;
    for (int i = 0; i < DIV_BITS; i++) begin
      step_part = {step_rem, step_quo[DIV_W-1]};
      step_quo  = {step_quo[DIV_W-2:0], 1'b0};
      if (step_part >= {1'b0, div_dvs_q}) begin
        step_part   = step_part - {1'b0, div_dvs_q};
        step_quo[0] = 1'b1;
      end
      step_rem = step_part[LEN_W-1:0];
    end
  end

  // next state and datapath
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && out_stall_i;
    nibble_d    = nibble_q;
    pos_d       = pos_q;
    base_d      = base_q;
    last_d      = last_q;
    now_d       = now_q;
    red_d       = red_q;
    div_quo_d   = div_quo_q;
    div_rem_d   = div_rem_q;
    div_dvs_d   = div_dvs_q;
    div_cnt_d   = div_cnt_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          unique case (command_i)
            CMD_WRITE: begin
              mem_we = wr_in_range;
            end
            CMD_SEEK: begin
              red_d   = RW'(track_prod);
              state_d = ST_SEEK;
            end
            CMD_READ: begin
              now_d     = cycle_count_i;
              div_quo_d = DIV_W'(delta);
              div_rem_d = '0;
              div_dvs_d = BTC;
              div_cnt_d = DIV_CNT_W'(DIV_STEPS);
              state_d   = ST_STEPS;
            end
            default: ;
          endcase
        end
      end

      // reduce the track base modulo the image size, one subtract a clock
      ST_SEEK: begin
        if (red_q >= IMG_R) begin
          red_d = red_q - IMG_R;
        end else begin
          base_d  = red_q[AW-1:0];
          state_d = ST_IDLE;
        end
      end

      // whole byte times gone by
      ST_STEPS: begin
        if (div_cnt_q != '0) begin
          div_quo_d = step_quo;
          div_rem_d = step_rem;
          div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
        end else if (steps != '0) begin
          // last read cycle moves by whole byte times: now less the remainder
          last_d    = now_q - CYC_W'(div_rem_q);
          div_quo_d = DIV_W'(pos_sum);
          div_rem_d = '0;
          div_dvs_d = eff_len;
          div_cnt_d = DIV_CNT_W'(DIV_STEPS);
          state_d   = ST_POS;
        end else begin
          state_d = ST_ADDR;
        end
      end

      // new position modulo the track length
      ST_POS: begin
        if (div_cnt_q != '0) begin
          div_quo_d = step_quo;
          div_rem_d = step_rem;
          div_cnt_d = div_cnt_q - DIV_CNT_W'(1);
        end else begin
          pos_d   = div_rem_q;
          state_d = ST_ADDR;
        end
      end

      ST_ADDR: begin
        mem_re  = 1'b1;
        state_d = ST_MEM;
      end

      // hand the byte to the output register once it is free
      ST_MEM: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          nibble_d    = rd_data_q;
          state_d     = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      pos_q       <= '0;
      base_q      <= '0;
      last_q      <= '0;
      div_cnt_q   <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pos_q       <= pos_d;
      base_q      <= base_d;
      last_q      <= last_d;
      div_cnt_q   <= div_cnt_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      track_length_q <= TRACK_LENGTH_RST;
      track_count_q  <= TRACK_COUNT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_TRACK_LENGTH: track_length_q <= cfg_data_i;
        CFG_TRACK_COUNT:  track_count_q  <= cfg_data_i[TCNT_W-1:0];
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    nibble_q  <= nibble_d;
    now_q     <= now_d;
    red_q     <= red_d;
    div_quo_q <= div_quo_d;
    div_rem_q <= div_rem_d;
    div_dvs_q <= div_dvs_d;
  end

  // image memory ports
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      image_mem[wr_idx] <= write_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_data_q <= image_mem[rd_idx];
    end
  end

endmodule

@@ test/nibble_track_reader_top_tb.sv @@
// self-checking testbench for the nibble track reader: random and directed items against a predictor
`timescale 1ns / 100ps

module nibble_track_reader_top_tb;
  import ntr_pkg::*;

  localparam int IMAGE_BYTES      = 262144;
  localparam int BYTE_TIME_CYCLES = 32;
  localparam int QUARTERS         = 4;
  localparam int CLK_PERIOD       = 4;
  localparam int RESET_CYCLES     = 9;
  localparam int SETTLE_CYCLES    = 40;
  localparam int LONG_HOLD        = 300;
  localparam int QUIET_LIMIT      = 2000;
  localparam int MAX_PRINTS       = 20;

  // command code the block must ignore
  localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;

  // one input item, every field present whatever the command
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
    logic [QT_W-1:0]   qt;
    logic [CYC_W-1:0]  cyc;
  } disk_op_t;

  // head and geometry of the emulated drive
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [TCNT_W-1:0] cnt;
    logic [LEN_W-1:0]  pos;
    logic [ADDR_W-1:0] base;
    logic [CYC_W-1:0]  last;
  } head_t;

  logic                 clk_i          = 1'b0;
  logic                 rst_ni         = 1'b0;
  logic                 in_valid_i     = 1'b0;
  logic                 in_stall_o;
  logic [CMD_W-1:0]     command_i      = '0;
  logic [ADDR_W-1:0]    byte_address_i = '0;
  logic [DATA_W-1:0]    write_data_i   = '0;
  logic [QT_W-1:0]      quarter_track_i = '0;
  logic [CYC_W-1:0]     cycle_count_i  = '0;
  logic                 out_valid_o;
  logic                 out_stall_i    = 1'b0;
  logic [DATA_W-1:0]    nibble_o;
  logic                 cfg_valid_i    = 1'b0;
  logic                 cfg_ready_o;
  cfg_idx_e             cfg_index_i    = CFG_TRACK_LENGTH;
  logic [LEN_W-1:0]     cfg_data_i     = '0;

  nibble_track_reader_top #(
    .IMAGE_BYTES      (IMAGE_BYTES),
    .BYTE_TIME_CYCLES (BYTE_TIME_CYCLES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .command_i       (command_i),
    .byte_address_i  (byte_address_i),
    .write_data_i    (write_data_i),
    .quarter_track_i (quarter_track_i),
    .cycle_count_i   (cycle_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .nibble_o        (nibble_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // plan_head runs ahead at queueing time so no read ever lands on an unwritten byte,
  // live_head follows the items the block actually accepts
  head_t            plan_head;
  head_t            live_head;
  bit               byte_loaded [IMAGE_BYTES];
  logic [DATA_W-1:0] disk_image [IMAGE_BYTES];

  disk_op_t          pending_ops[$];
  logic [DATA_W-1:0] nibble_due[$];
  disk_op_t          cur_op;
  logic [ADDR_W-1:0] live_addr;

  int  errors     = 0;
  int  n_sent     = 0;
  int  n_checked  = 0;
  int  n_geom     = 1;
  int  send_gap   = 0;
  int  stall_left = 0;
  int  hold_left  = 0;
  int  hold_asked = 0;
  int  hold_taken = 0;
  int  quiet      = 0;
  bit  calm       = 1'b0;

  // next head state after one item; writes and unknown codes leave it alone
  function automatic head_t head_next(head_t h, disk_op_t op);
    longint unsigned span, track, tracks, gap, steps;
    span = (h.len == 0) ? 1 : h.len;
    if (op.cmd == CMD_SEEK) begin
      track  = op.qt / QUARTERS;
      tracks = (h.cnt == 0) ? 1 : h.cnt;
      if (track >= tracks) track = tracks - 1;
      h.base = ADDR_W'((track * span) % IMAGE_BYTES);
    end else if (op.cmd == CMD_READ) begin
      gap   = (op.cyc > h.last) ? op.cyc - h.last : 0;
      steps = gap / BYTE_TIME_CYCLES;
      if (steps != 0) begin
        // a position left above a shrunk track length only drops on the next advance
        h.pos  = LEN_W'((h.pos + steps) % span);
        h.last = CYC_W'(h.last + steps * BYTE_TIME_CYCLES);
      end
    end
    return h;
  endfunction

  // image byte under the head, wrapping round the image
  function automatic logic [ADDR_W-1:0] head_addr(head_t h);
    longint unsigned sum;
    sum = longint'(h.base) + longint'(h.pos);
    return ADDR_W'(sum % IMAGE_BYTES);
  endfunction

  // item with every field random, then the command forced
  function automatic disk_op_t rand_op(logic [CMD_W-1:0] c);
    disk_op_t op;
    op.cmd  = c;
    op.addr = ADDR_W'($urandom);
    op.data = DATA_W'($urandom);
    op.qt   = QT_W'($urandom);
    op.cyc  = CYC_W'({$urandom, $urandom});
    return op;
  endfunction

  task automatic flag_mismatch(string what, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
    if (errors < MAX_PRINTS)
      $display("%0t ns: %s, got %h want %h", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // sender: takes items from the pending queue, with random gaps between them
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      // accepted item: move the live head and, for a read, note the nibble due
      if (in_valid_i && !in_stall_o) begin
        if (cur_op.cmd == CMD_WRITE) begin
          disk_image[cur_op.addr] = cur_op.data;
        end else begin
          live_head = head_next(live_head, cur_op);
          live_addr = head_addr(live_head);
          if (cur_op.cmd == CMD_READ) nibble_due.push_back(disk_image[live_addr]);
        end
      end
      // the slot is free once the current item has gone or none is up
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_ops.size() != 0) begin
          cur_op          = pending_ops.pop_front();
          command_i       <= cur_op.cmd;
          byte_address_i  <= cur_op.addr;
          write_data_i    <= cur_op.data;
          quarter_track_i <= cur_op.qt;
          cycle_count_i   <= cur_op.cyc;
          in_valid_i      <= 1'b1;
          if (!calm && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: checks each nibble against the oldest one due, stalls in bursts
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (nibble_due.size() == 0) begin
          flag_mismatch("nibble with none due", nibble_o, '0);
        end else begin
          if (nibble_o !== nibble_due[0]) flag_mismatch("nibble differs", nibble_o, nibble_due[0]);
          void'(nibble_due.pop_front());
        end
        n_checked++;
      end
      // a long hold asked by the sequence, so the block fills and stalls its input
      if (hold_taken != hold_asked) begin
        hold_taken = hold_asked;
        hold_left  = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        stall_left = $urandom_range(0, 8);
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog: too long with no handshake on any channel
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet = 0;
    else
      quiet++;
    if (quiet == QUIET_LIMIT) begin
      $display("timeout: no handshake for %0d cycles, %0d nibbles still due",
               QUIET_LIMIT, nibble_due.size());
      $display("** nibble_track_reader_top: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // sequence helpers
  // ---------------------------------------------------------------------------
  task automatic push_op(disk_op_t op);
    if (op.cmd == CMD_WRITE) byte_loaded[op.addr] = 1'b1;
    plan_head = head_next(plan_head, op);
    pending_ops.push_back(op);
    n_sent++;
  endtask

  task automatic send_write(logic [ADDR_W-1:0] a, logic [DATA_W-1:0] d);
    disk_op_t op;
    op      = rand_op(CMD_WRITE);
    op.addr = a;
    op.data = d;
    push_op(op);
  endtask

  task automatic send_seek(logic [QT_W-1:0] q);
    disk_op_t op;
    op    = rand_op(CMD_SEEK);
    op.qt = q;
    push_op(op);
  endtask

  // a read whose byte has never been loaded gets a write to it first
  task automatic send_read(logic [CYC_W-1:0] c);
    disk_op_t op;
    head_t    peek;
    logic [ADDR_W-1:0] a;
    op   = rand_op(CMD_READ);
    op.cyc = c;
    peek = head_next(plan_head, op);
    a    = head_addr(peek);
    if (!byte_loaded[a]) send_write(a, DATA_W'($urandom));
    push_op(op);
  endtask

  task automatic send_random(int n);
    int k;
    logic [CYC_W-1:0] back;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        case ($urandom_range(0, 9))
          0: begin
            // cycle count at or below the last read: nothing advances
            back = (plan_head.last > 200) ? CYC_W'($urandom_range(1, 200)) : plan_head.last;
            send_read(plan_head.last - back);
          end
          1:       send_read(plan_head.last + $urandom_range(0, 1 << 20));
          default: send_read(plan_head.last + $urandom_range(0, 400));
        endcase
      end else if (k < 65) begin
        send_seek(QT_W'($urandom_range(0, 255)));
      end else if (k < 93) begin
        send_write(ADDR_W'($urandom), DATA_W'($urandom));
      end else begin
        push_op(rand_op(CMD_UNKNOWN));
      end
    end
  endtask

  // wait for the sender to drain and every nibble to arrive, then let the block go quiet;
  // checked on the falling edge so the sender's work at the rising edge is already done
  task automatic settle();
    @(negedge clk_i);
    while (pending_ops.size() != 0 || in_valid_i || nibble_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [LEN_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_TRACK_LENGTH) begin
      plan_head.len = val;
      live_head.len = val;
    end else begin
      plan_head.cnt = val[TCNT_W-1:0];
      live_head.cnt = val[TCNT_W-1:0];
    end
  endtask

  // new track geometry, written only with the block idle
  task automatic set_geometry(logic [LEN_W-1:0] len, logic [LEN_W-1:0] cnt);
    settle();
    write_reg(CFG_TRACK_LENGTH, len);
    write_reg(CFG_TRACK_COUNT, cnt);
    cfg_valid_i <= 1'b0;
    n_geom++;
  endtask

  // ---------------------------------------------------------------------------
  // the run
  // ---------------------------------------------------------------------------
  initial begin
    plan_head = '{len: TRACK_LENGTH_RST, cnt: TRACK_COUNT_RST, pos: '0, base: '0, last: '0};
    live_head = plan_head;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, reset geometry: address and data extremes
    send_write('0, 8'h00);
    send_write('1, 8'hff);
    send_write(18'h2aaaa, 8'ha5);
    send_write(18'h15555, 8'h5a);
    // first read, less than a byte time, exactly one, then a count that went backwards
    send_read('0);
    send_read(CYC_W'(BYTE_TIME_CYCLES - 1));
    send_read(CYC_W'(BYTE_TIME_CYCLES));
    send_read(CYC_W'(5));
    // position wraps back to the start of the track
    send_read(plan_head.last + BYTE_TIME_CYCLES * (TRACK_LENGTH_RST - 1));
    // seeks inside a track, onto the last track, and past it (clamped)
    send_seek(8'd0);
    send_seek(8'd3);
    send_read(plan_head.last + 40);
    send_seek(8'd4);
    send_read(plan_head.last + 64);
    send_seek(8'd139);
    send_read(plan_head.last);
    send_seek(8'd140);
    send_read(plan_head.last + 100);
    send_seek(8'd255);
    send_read(plan_head.last + 32);
    push_op(rand_op(CMD_UNKNOWN));
    push_op(rand_op(CMD_UNKNOWN));

    // widest geometry: track base and base plus position wrap round the image
    set_geometry('1, 13'd40);
    send_seek(8'd159);
    send_read(plan_head.last + BYTE_TIME_CYCLES * 8190);
    send_seek(8'd128);
    send_read(plan_head.last + BYTE_TIME_CYCLES * 100);
    send_read(plan_head.last + BYTE_TIME_CYCLES * 8000);

    // zero length and zero count both behave as one
    set_geometry('0, '0);
    send_seek(8'd255);
    send_read(plan_head.last + 64);
    send_read(plan_head.last + BYTE_TIME_CYCLES * 7);
    set_geometry('0, 13'd63);
    send_seek(8'd255);
    send_read(plan_head.last + 32);
    send_seek(8'd8);
    send_read(plan_head.last + 96);

    // shrink the track under a far position: kept until the next advance
    set_geometry(13'd1000, 13'd8);
    send_read(plan_head.last + BYTE_TIME_CYCLES * 900 + 5);
    set_geometry(13'd5, 13'd8);
    send_read(plan_head.last + 10);
    send_read(plan_head.last + 31);
    send_read(plan_head.last + BYTE_TIME_CYCLES * 3);

    // random phases over several geometries
    set_geometry(13'd16, 13'd8);
    send_random(60);
    set_geometry(13'd6656, 13'd40);
    send_random(30);
    hold_asked <= hold_asked + 1;   // receiver holds off while the sender keeps going
    send_random(40);
    set_geometry(13'd7, 13'd1);
    send_random(60);
    set_geometry(13'd1, 13'd63);
    send_random(50);
    set_geometry(LEN_W'($urandom_range(1, 8191)), LEN_W'($urandom_range(1, 40)));
    send_random(60);

    // last part: no idling on either side, then the far end of the cycle counter
    set_geometry(TRACK_LENGTH_RST, LEN_W'(TRACK_COUNT_RST));
    calm <= 1'b1;
    send_random(50);
    repeat (4) send_read(CYC_W'({$urandom, $urandom}));
    send_read('1);
    send_read('1);

    settle();
    $display("%0d items sent, %0d nibbles checked, %0d track geometries",
             n_sent, n_checked, n_geom);
    $display("covered clamped seeks, zero geometry, image wrap, backward counts, long output hold");
    if (errors == 0 && nibble_due.size() == 0) begin
      $display("** nibble_track_reader_top: PASSED **");
    end else begin
      $display("** nibble_track_reader_top: FAILED **");
    end
    $finish;
  end

endmodule
